### src/cle_pkg.sv
// shared types and constants for the console line editor
// used by console_line_editor; depends on nothing else
package cle_pkg;

  localparam int BYTE_W         = 8;
  localparam int CAP_W          = 6;
  localparam int DEF_LINE_DEPTH = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam logic [CAP_W-1:0] CAP_MIN   = 6'd2;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  localparam logic DEST_ECHO = 1'b0;
  localparam logic DEST_LINE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ECHO,
    S_NL,
    S_BS1,
    S_SP,
    S_BS2,
    S_LREAD,
    S_LPUT,
    S_TERM
  } cle_state_t;

  // what follows the echo of the received byte
  typedef enum logic [1:0] {
    K_ECHO,
    K_EOL,
    K_ERASE,
    K_FLUSH
  } cle_kind_t;

endpackage

### src/console_line_editor.sv
// console line editor: echo, erase and line assembly over a line store with one write and one read port
// depends on cle_pkg for character codes, sequencer states and widths
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | in        | in_valid / in_stall  | rx_byte
//  out     | out       | out_valid / out_stall| dest, out_byte, last
//  cfg     | in        | cfg_wr_en            | cfg_wr_data (line_capacity)
//
// one item at a time: results leave one per cycle while out_stall is low,
// and a completed line first passes through S_LREAD for the line store read.
// rst is synchronous: clears the fill count, the sequencer and the output stage
// and sets line_capacity to 32; the line store itself is not cleared.
// out_stall holds the output register and the sequencer; in_stall is low only
// when the sequencer is idle, even while the last result is still waiting.
module console_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::DEF_LINE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cle_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       dest,
  output logic [cle_pkg::BYTE_W-1:0] out_byte,
  output logic                       last,
  input  logic                       cfg_wr_en,
  input  logic [cle_pkg::CAP_W-1:0]  cfg_wr_data
);
  import cle_pkg::*;

  localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int DEP_W = $clog2(LINE_DEPTH + 1);
  localparam int CMP_W = (CAP_W > DEP_W) ? CAP_W : DEP_W;

  cle_state_t state, state_next;
  cle_kind_t  kind, kind_next;

  logic [CAP_W-1:0]  line_capacity;
  logic [IDX_W-1:0]  fill_count;
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] cur_byte;

  logic [BYTE_W-1:0] line_store [LINE_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic              in_take;
  logic              out_free;
  logic              push;
  logic              push_dest;
  logic [BYTE_W-1:0] push_byte;
  logic              push_last;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;

  logic [CMP_W-1:0]  cap_ext, eff_cap, full, fill_ext, fill_inc;
  logic              is_eol, is_erase, is_print;
  logic              fill_empty, idx_at_end;

  // effective capacity, saturated to 2 .. LINE_DEPTH
  always_comb begin
    cap_ext = CMP_W'(line_capacity);
    if (cap_ext < CMP_W'(CAP_MIN)) begin
      eff_cap = CMP_W'(CAP_MIN);
    end else if (cap_ext > CMP_W'(LINE_DEPTH)) begin
      eff_cap = CMP_W'(LINE_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    full     = eff_cap - CMP_W'(1);
    fill_ext = CMP_W'(fill_count);
    fill_inc = fill_ext + CMP_W'(1);
  end

  assign is_eol     = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_erase   = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  assign is_print   = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
  assign fill_empty = (fill_count == '0);
  assign idx_at_end = ((idx + IDX_W'(1)) == fill_count);

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wr_en    = in_take && is_print && (fill_ext < full);

  always_comb begin
    kind_next = K_ECHO;
    if (is_eol) begin
      kind_next = K_EOL;
    end else if (is_erase) begin
      kind_next = fill_empty ? K_ECHO : K_ERASE;
    end else if (is_print) begin
      if (fill_ext < full) begin
        kind_next = (fill_inc >= full) ? K_FLUSH : K_ECHO;
      end else begin
        kind_next = K_FLUSH;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) state_next = S_ECHO;
      end
      S_ECHO: begin
        if (out_free) begin
          case (kind)
            K_EOL:   state_next = S_NL;
            K_ERASE: state_next = S_BS1;
            K_FLUSH: state_next = fill_empty ? S_TERM : S_LREAD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_NL: begin
        if (out_free) state_next = fill_empty ? S_TERM : S_LREAD;
      end
      S_BS1: begin
        if (out_free) state_next = S_SP;
      end
      S_SP: begin
        if (out_free) state_next = S_BS2;
      end
      S_BS2: begin
        if (out_free) state_next = S_IDLE;
      end
      S_LREAD: state_next = S_LPUT;
      S_LPUT: begin
        if (out_free && idx_at_end) state_next = S_TERM;
      end
      S_TERM: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    push      = 1'b0;
    push_dest = DEST_ECHO;
    push_byte = cur_byte;
    push_last = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_ECHO: begin
        push      = out_free;
        push_last = (kind == K_ECHO);
      end
      S_NL: begin
        push      = out_free;
        push_byte = CH_LF;
      end
      S_BS1: begin
        push      = out_free;
        push_byte = CH_BS;
      end
      S_SP: begin
        push      = out_free;
        push_byte = CH_SPACE;
      end
      S_BS2: begin
        push      = out_free;
        push_byte = CH_BS;
        push_last = 1'b1;
      end
      S_LREAD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      S_LPUT: begin
        push      = out_free;
        push_dest = DEST_LINE;
        push_byte = rd_data;
        // fetch the next stored byte as this one leaves
        rd_en     = out_free && !idx_at_end;
        rd_addr   = idx + IDX_W'(1);
      end
      S_TERM: begin
        push      = out_free;
        push_dest = DEST_LINE;
        push_byte = CH_NUL;
        push_last = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kind          <= K_ECHO;
      fill_count    <= '0;
      idx           <= '0;
      line_capacity <= CAP_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) line_capacity <= cfg_wr_data;
      if (in_take) begin
        kind <= kind_next;
        idx  <= '0;
        if (wr_en) begin
          fill_count <= fill_count + IDX_W'(1);
        end else if (is_erase && !fill_empty) begin
          fill_count <= fill_count - IDX_W'(1);
        end
      end
      if (state == S_LPUT && out_free) idx <= idx + IDX_W'(1);
      if (state == S_TERM && out_free) fill_count <= '0;
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) cur_byte <= rx_byte;
    if (push) begin
      dest     <= push_dest;
      out_byte <= push_byte;
      last     <= push_last;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) line_store[fill_count] <= rx_byte;
    if (rd_en) rd_data <= line_store[rd_addr];
  end

endmodule
